>>> design/bslp_pkg.sv
// shared types, constants and decode helpers for the button press classifier
// no dependencies
package bslp_pkg;

   localparam int unsigned BtnWidth    = 6;
   localparam int unsigned TickWidth   = 32;
   localparam int unsigned ThreshWidth = 16;
   localparam int unsigned EventWidth  = 4;
   localparam int unsigned AddrWidth   = 3;

   localparam logic [ThreshWidth-1:0] ThreshReset = 16'd400;
   localparam logic [BtnWidth-1:0]    BothRightLeft = 6'h03;

   // register byte addresses
   localparam logic [AddrWidth-1:0] AddrHoldThreshold = 3'd0;

   // event codes
   localparam logic [EventWidth-1:0] EvNone        = 4'd0;
   localparam logic [EventWidth-1:0] EvShortRight  = 4'd1;
   localparam logic [EventWidth-1:0] EvShortLeft   = 4'd2;
   localparam logic [EventWidth-1:0] EvShortUp     = 4'd3;
   localparam logic [EventWidth-1:0] EvShortDown   = 4'd4;
   localparam logic [EventWidth-1:0] EvShortCenter = 4'd5;
   localparam logic [EventWidth-1:0] EvShortAction = 4'd6;
   localparam logic [EventWidth-1:0] EvLongBase    = 4'd6;
   localparam logic [EventWidth-1:0] EvLast        = 4'd12;

   // one poll
   typedef struct packed {
      logic [BtnWidth-1:0]  buttons;
      logic [TickWidth-1:0] tick_now;
   } poll_type;

   // one classification result
   typedef struct packed {
      logic [EventWidth-1:0] event_res;
      logic [TickWidth-1:0]  last_active_tick;
   } result_type;

   // short code of a single pressed button, none otherwise
   function automatic logic [EventWidth-1:0] single_code(input logic [BtnWidth-1:0] p);
      logic [EventWidth-1:0] c;
      case (p)
         6'h01:   c = EvShortRight;
         6'h02:   c = EvShortLeft;
         6'h04:   c = EvShortUp;
         6'h08:   c = EvShortDown;
         6'h10:   c = EvShortCenter;
         6'h20:   c = EvShortAction;
         default: c = EvNone;
      endcase
      return c;
   endfunction

endpackage

>>> design/button_short_long_press_classifier.sv
// button press classifier: a req transfer passes through the input register, then is decoded
// into the result register before the earliest rsp transfer; one poll per cycle
// sustained while rsp_ready stays high, limited by the single decode stage and the result register
// synchronous active-high reset clears the press state, empties both stages
// and sets hold_threshold to 400
module button_short_long_press_classifier
   import bslp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // poll channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [BtnWidth-1:0]    req_buttons,
   input  logic [TickWidth-1:0]   req_tick_now,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [EventWidth-1:0]  rsp_event_res,
   output logic [TickWidth-1:0]   rsp_last_active_tick,
   // register port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [AddrWidth-1:0]   csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   logic                   in_valid_ff, in_valid_in;
   poll_type               in_poll_ff;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_result_ff;
   logic [ThreshWidth-1:0] hold_threshold_ff;
   logic                   advance;
   logic                   accept;
   result_type             result;

   // stage flow control
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign accept      = req_valid && req_ready;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_poll_ff.buttons  <= req_buttons;
         in_poll_ff.tick_now <= req_tick_now;
      end
   end

   bslp_core u_core (
      .clock          (clock),
      .reset          (reset),
      .fire           (advance),
      .poll           (in_poll_ff),
      .hold_threshold (hold_threshold_ff),
      .result         (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_event_res        = out_result_ff.event_res;
   assign rsp_last_active_tick = out_result_ff.last_active_tick;

   // register write transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_threshold_ff <= ThreshReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == AddrHoldThreshold) begin
         hold_threshold_ff <= csr_pwdata[ThreshWidth-1:0];
      end
   end

   // register read back
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == AddrHoldThreshold) begin
         csr_prdata = {{(32-ThreshWidth){1'b0}}, hold_threshold_ff};
      end
   end

   assign csr_pready = 1'b1;

endmodule

>>> design/bslp_core.sv
// press state and event decode for one poll per cycle while fire is asserted
// depends on bslp_pkg
module bslp_core
   import bslp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  poll_type               poll,
   input  logic [ThreshWidth-1:0] hold_threshold,
   output result_type             result
);

   logic [BtnWidth-1:0]  prev_pattern_ff, prev_pattern_in;
   logic [TickWidth-1:0] change_tick_ff, change_tick_in;
   logic [TickWidth-1:0] active_tick_ff, active_tick_in;

   logic [TickWidth-1:0]  elapsed;
   logic [TickWidth-1:0]  thresh_ext;
   logic [EventWidth-1:0] code;
   logic [EventWidth-1:0] ev;

   assign elapsed    = poll.tick_now - change_tick_ff;
   assign thresh_ext = {{(TickWidth-ThreshWidth){1'b0}}, hold_threshold};

   // classify the poll against the latched pattern
   always_comb begin
      prev_pattern_in = prev_pattern_ff;
      change_tick_in  = change_tick_ff;
      active_tick_in  = active_tick_ff;
      ev              = EvNone;
      code            = EvNone;
      if (poll.buttons != '0) begin
         active_tick_in = poll.tick_now;
      end
      if (poll.buttons == prev_pattern_ff) begin
         code = single_code(poll.buttons);
         if (poll.buttons != '0 && elapsed > thresh_ext && code != EvNone) begin
            ev = code + EvLongBase;
         end
      end else begin
         change_tick_in = poll.tick_now;
         if (poll.buttons != '0) begin
            // right+left together stays latched until full release
            prev_pattern_in = (prev_pattern_ff == BothRightLeft) ? BothRightLeft
                                                                 : poll.buttons;
         end else begin
            prev_pattern_in = '0;
            if (elapsed < thresh_ext) begin
               ev = single_code(prev_pattern_ff);
            end
         end
      end
   end

   // state update on each processed poll
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pattern_ff <= '0;
         change_tick_ff  <= '0;
         active_tick_ff  <= '0;
      end else if (fire) begin
         prev_pattern_ff <= prev_pattern_in;
         change_tick_ff  <= change_tick_in;
         active_tick_ff  <= active_tick_in;
      end
   end

   assign result.event_res        = ev;
   assign result.last_active_tick = active_tick_in;

endmodule

>>> design/bslp_checker.sv
// port-level checks for the button press classifier, bound to the top level
// depends on bslp_pkg and button_short_long_press_classifier
module bslp_checker
   import bslp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [EventWidth-1:0] rsp_event_res,
   input logic [TickWidth-1:0]  rsp_last_active_tick
);

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res)
                                 && $stable(rsp_last_active_tick))
      else $error("stalled result changed");

   // an empty result register never blocks the poll channel
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("poll channel blocked with empty output");

   // event codes stay within the defined set
   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_res <= EvLast)
      else $error("event code out of range");

   // a poll transfer into an empty pipeline reaches the result register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid && rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("result missing after poll transfer");

endmodule

bind button_short_long_press_classifier bslp_checker u_bslp_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_event_res        (rsp_event_res),
   .rsp_last_active_tick (rsp_last_active_tick)
);
